[rtl/sfsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_pkg
// Shared types and constants for the smallest-factor sieve and prime emitter.
// ----------------------------------------------------------------------------
package sfsp_pkg;

    localparam int VAL_W      = 9;
    localparam int POS_W      = 6;
    localparam int TOT_W      = 7;
    localparam int RESULT_CAP = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_MARK_DRAIN,
        ST_COUNT,
        ST_COUNT_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_CHK
    } sfsp_state_t;

    // table access for one cycle, numbers are 1-based
    typedef struct packed {
        logic             wr_en;
        logic [VAL_W-1:0] wr_num;
        logic [VAL_W-1:0] wr_data;
        logic             rd_en;
        logic [VAL_W-1:0] rd_num;
    } sfsp_tbl_req_t;

endpackage

[rtl/sfsp_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_table
// Smallest-factor table: one write port, one read port with registered,
// enabled read data. Entry for number k sits at address k-1.
// ----------------------------------------------------------------------------
module sfsp_table
    import sfsp_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic             aclk,
    input  sfsp_tbl_req_t    req,
    output logic [VAL_W-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] wr_off;
    logic [VAL_W-1:0] rd_off;
    logic [VAL_W-1:0] rd_data_reg;

    assign wr_off  = req.wr_num - VAL_W'(1);
    assign rd_off  = req.rd_num - VAL_W'(1);
    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_off[AW-1:0]] <= req.wr_data;
        end
        // read data holds while the read port is idle
        if (req.rd_en) begin
            rd_data_reg <= mem[rd_off[AW-1:0]];
        end
    end

endmodule

[rtl/smallest_factor_sieve_primes_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_factor_sieve_primes_unit
// Builds a smallest-factor table for 1..n in a single-port-pair memory, then
// emits 1 and every prime up to n in ascending order with position and total.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_limit
//  m_      | out       | m_valid / m_ready  | m_prime_value, m_position,
//          |           |                    | m_prime_total, m_last_flag
//
// Per request, accept to accept: clear the n entries, mark every multiple at
// one table access per cycle, count pass over the n entries, emit pass reading
// each entry and then checking it. The table's single read port sets the pace.
// s_ready is high only when idle; a limit of 0 returns to idle at once.
// A stalled m_ready holds the emit pass on the current entry.
// Reset is synchronous, active low; the table itself is not cleared.
// ----------------------------------------------------------------------------
module smallest_factor_sieve_primes_unit
    import sfsp_pkg::*;
#(
    parameter int MAX_LIMIT = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VAL_W-1:0] s_limit,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_prime_value,
    output logic [POS_W-1:0] m_position,
    output logic [TOT_W-1:0] m_prime_total,
    output logic             m_last_flag
);

    localparam logic [VAL_W-1:0] LIMIT_MAX = VAL_W'(MAX_LIMIT);
    localparam logic [VAL_W-1:0] ONE       = VAL_W'(1);
    localparam logic [TOT_W-1:0] CAP       = TOT_W'(RESULT_CAP);

    sfsp_state_t      state_reg, state_next;
    logic [VAL_W-1:0] n_reg, n_next;
    logic [VAL_W-1:0] d_reg, d_next;
    logic [VAL_W-1:0] m_reg, m_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [VAL_W-1:0] pend_num_reg, pend_num_next;
    logic [VAL_W-1:0] pend_d_reg, pend_d_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic [TOT_W-1:0] count_reg, count_next;
    logic [TOT_W-1:0] emit_cnt_reg, emit_cnt_next;

    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic [TOT_W-1:0] out_total_reg, out_total_next;
    logic             out_last_reg, out_last_next;

    sfsp_tbl_req_t    tbl_req;
    logic [VAL_W-1:0] rd_data;
    logic [VAL_W-1:0] lim_sat;
    logic [VAL_W:0]   next_mult;
    logic             out_free;
    logic             keep;
    logic             emit;

    sfsp_table #(
        .DEPTH (MAX_LIMIT)
    ) u_table (
        .aclk    (aclk),
        .req     (tbl_req),
        .rd_data (rd_data)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_prime_value = out_value_reg;
    assign m_position    = out_pos_reg;
    assign m_prime_total = out_total_reg;
    assign m_last_flag   = out_last_reg;

    assign lim_sat   = (s_limit > LIMIT_MAX) ? LIMIT_MAX : s_limit;
    assign next_mult = {1'b0, m_reg} + {1'b0, d_reg};
    assign out_free  = !m_valid_reg || m_ready;
    assign keep      = (rd_data >= last_reg);
    assign emit      = keep && (emit_cnt_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        m_reg         <= m_next;
        pend_num_reg  <= pend_num_next;
        pend_d_reg    <= pend_d_next;
        last_reg      <= last_next;
        count_reg     <= count_next;
        emit_cnt_reg  <= emit_cnt_next;
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        pend_vld_next  = 1'b0;
        pend_num_next  = pend_num_reg;
        pend_d_next    = pend_d_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        tbl_req        = '0;

        // read issued last cycle: mark on the way back, or count keepers
        if (pend_vld_reg) begin
            if (state_reg == ST_MARK || state_reg == ST_MARK_DRAIN) begin
                if (rd_data == ONE) begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_num  = pend_num_reg;
                    tbl_req.wr_data = pend_d_reg;
                end
            end else if (keep) begin
                last_next = rd_data;
                if (count_reg < CAP) begin
                    count_next = count_reg + TOT_W'(1);
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next = lim_sat;
                    m_next = ONE;
                    if (lim_sat != '0) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_num  = m_reg;
                tbl_req.wr_data = ONE;
                if (m_reg == n_reg) begin
                    if (n_reg < VAL_W'(2)) begin
                        state_next = ST_COUNT;
                        m_next     = ONE;
                        last_next  = ONE;
                        count_next = '0;
                    end else begin
                        state_next = ST_MARK;
                        d_next     = VAL_W'(2);
                        m_next     = VAL_W'(2);
                    end
                end else begin
                    m_next = m_reg + ONE;
                end
            end
            ST_MARK: begin
                tbl_req.rd_en = 1'b1;
                tbl_req.rd_num = m_reg;
                pend_vld_next = 1'b1;
                pend_num_next = m_reg;
                pend_d_next   = d_reg;
                if (next_mult <= {1'b0, n_reg}) begin
                    m_next = next_mult[VAL_W-1:0];
                end else if (d_reg < n_reg) begin
                    d_next = d_reg + ONE;
                    m_next = d_reg + ONE;
                end else begin
                    state_next = ST_MARK_DRAIN;
                end
            end
            ST_MARK_DRAIN: begin
                state_next = ST_COUNT;
                m_next     = ONE;
                last_next  = ONE;
                count_next = '0;
            end
            ST_COUNT: begin
                tbl_req.rd_en  = 1'b1;
                tbl_req.rd_num = m_reg;
                pend_vld_next  = 1'b1;
                if (m_reg == n_reg) begin
                    state_next = ST_COUNT_DRAIN;
                end else begin
                    m_next = m_reg + ONE;
                end
            end
            ST_COUNT_DRAIN: begin
                // count keeps the last update, the kept value restarts
                state_next    = ST_EMIT_RD;
                m_next        = ONE;
                last_next     = ONE;
                emit_cnt_next = '0;
            end
            ST_EMIT_RD: begin
                tbl_req.rd_en  = 1'b1;
                tbl_req.rd_num = m_reg;
                state_next     = ST_EMIT_CHK;
            end
            ST_EMIT_CHK: begin
                if (!(emit && !out_free)) begin
                    if (keep) begin
                        last_next = rd_data;
                    end
                    if (emit) begin
                        m_valid_next   = 1'b1;
                        out_value_next = rd_data;
                        out_pos_next   = emit_cnt_reg[POS_W-1:0];
                        out_total_next = count_reg;
                        out_last_next  = ((emit_cnt_reg + TOT_W'(1)) == count_reg);
                        emit_cnt_next  = emit_cnt_reg + TOT_W'(1);
                    end
                    if (m_reg == n_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        m_next     = m_reg + ONE;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
